/* src/hbs_pkg.sv */
// Shared types and constants for the heightmap bilinear sampler.
`timescale 1ns / 1ps

package hbs_pkg;

  // Field widths of the item and configuration interfaces.
  localparam int HEIGHT_W  = 16;
  localparam int COORD_W   = 16;
  localparam int QPOS_W    = 24;
  localparam int CFG_W     = 16;
  localparam int CFG_IDX_W = 2;

  // Command codes.
  localparam logic CMD_WRITE = 1'b0;
  localparam logic CMD_QUERY = 1'b1;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] REG_MIN_X = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_MAX_X = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_MIN_Z = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_MAX_Z = 2'd3;

  // Configuration reset values.
  localparam logic signed [CFG_W-1:0] RESET_MIN = 16'sd0;
  localparam logic signed [CFG_W-1:0] RESET_MAX = 16'sd127;

  // Sequencer states.
  typedef enum logic [3:0] {
    ST_IDLE,
    ST_CLAMP,
    ST_OFFS,
    ST_RD0,
    ST_RD1,
    ST_RD2,
    ST_RD3,
    ST_L0_MUL,
    ST_L0_ADD,
    ST_L1_MUL,
    ST_L1_ADD,
    ST_L2_MUL,
    ST_L2_ADD
  } state_t;

endpackage

/* src/hbs_ram.sv */
// Generic single-port RAM with registered read data.
`timescale 1ns / 1ps

module hbs_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 16384
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // One access per cycle; read data appears after the clock edge.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end

endmodule

/* src/heightmap_bilinear_sampler.sv */
// Heightmap bilinear sampler top level: grid store, sequencer and shared lerp unit.
// A write is applied in the state after its transfer, and the block then returns to idle for the next input.
// A query runs through four single-port grid reads and three passes through one shared
// multiply and add unit; the next input is taken once the result is loaded. Reset
// clears control state and sets the bounds to 0..127; grid contents stay undefined
// until written, no clearing.
`timescale 1ns / 1ps

module heightmap_bilinear_sampler #(
  parameter int GRID_DIM  = 128,
  parameter int FRAC_BITS = 8
) (
  input  logic                                   clk,
  input  logic                                   rst,
  // Configuration write port
  input  logic                                   cfg_we,
  input  logic [hbs_pkg::CFG_IDX_W-1:0]          cfg_index,
  input  logic [hbs_pkg::CFG_W-1:0]              cfg_data,
  // Input channel
  input  logic                                   in_valid,
  output logic                                   in_ready,
  input  logic                                   command,
  input  logic signed [hbs_pkg::COORD_W-1:0]     cell_x,
  input  logic signed [hbs_pkg::COORD_W-1:0]     cell_z,
  input  logic signed [hbs_pkg::HEIGHT_W-1:0]    write_height,
  input  logic signed [hbs_pkg::QPOS_W-1:0]      query_x,
  input  logic signed [hbs_pkg::QPOS_W-1:0]      query_z,
  // Output channel
  output logic                                   out_valid,
  input  logic                                   out_ready,
  output logic signed [hbs_pkg::HEIGHT_W-1:0]    sampled_height
);

  import hbs_pkg::*;

  localparam int DEPTH = GRID_DIM * GRID_DIM;
  localparam int AW    = $clog2(DEPTH);
  localparam int IW    = $clog2(GRID_DIM);
  // Clamped position width: holds the query and (bound +/- 1) scaled by 2**FRAC_BITS.
  localparam int CW    = ((17 + FRAC_BITS > QPOS_W) ? 17 + FRAC_BITS : QPOS_W) + 1;
  // Lerp product width: 17-bit difference times an unsigned fraction.
  localparam int PW    = HEIGHT_W + 2 + FRAC_BITS;
  localparam int DXW   = COORD_W + 1;

  state_t state, state_next;

  // Configuration registers.
  logic signed [CFG_W-1:0] grid_min_x, grid_max_x, grid_min_z, grid_max_z;

  // Captured input item.
  logic                        cmd_q;
  logic signed [COORD_W-1:0]   cell_x_q, cell_z_q;
  logic signed [HEIGHT_W-1:0]  wheight_q;
  logic signed [QPOS_W-1:0]    qx_q, qz_q;

  // Query working registers.
  logic signed [CW-1:0]        px_q, pz_q;
  logic [IW-1:0]               ox_q, oz_q;
  logic [FRAC_BITS-1:0]        fx_q, fz_q;
  logic signed [HEIGHT_W-1:0]  h0_q, h1_q, h2_q, h3_q;
  logic signed [HEIGHT_W-1:0]  lerp_a_q, lerp_b_q;
  logic signed [PW-1:0]        prod_q;

  // Grid memory port.
  logic                        ram_we;
  logic [AW-1:0]               ram_addr;
  logic [HEIGHT_W-1:0]         ram_rdata;

  // Shared unit operands and results.
  logic signed [HEIGHT_W-1:0]  op_a, op_b;
  logic [FRAC_BITS-1:0]        op_f;
  logic signed [PW-1:0]        mul_res;
  logic signed [PW-1:0]        add_sum;
  logic signed [HEIGHT_W-1:0]  add_res;

  logic                        load_out;
  logic signed [DXW-1:0]       wdx, wdz;
  logic                        write_in_grid;
  logic [IW-1:0]               ox1, oz1;

  // Clamp one axis; the low bound is tested first, so on inverted bounds it wins only below it.
  function automatic logic signed [CW-1:0] clamp_axis(
    input logic signed [QPOS_W-1:0] p,
    input logic signed [CFG_W-1:0]  mn,
    input logic signed [CFG_W-1:0]  mx
  );
    logic signed [CW-1:0] pe, lo, hi, res;
    pe = CW'(p);
    lo = (CW'(mn) + CW'(1)) <<< FRAC_BITS;
    hi = (CW'(mx) - CW'(1)) <<< FRAC_BITS;
    priority if (pe < lo) begin
      res = lo;
    end else if (pe > hi) begin
      res = hi;
    end else begin
      res = pe;
    end
    return res;
  endfunction

  // Floor to the integer cell, subtract the minimum and saturate to 0..GRID_DIM-2.
  function automatic logic [IW-1:0] cell_offset(
    input logic signed [CW-1:0]    p,
    input logic signed [CFG_W-1:0] mn
  );
    logic signed [CW-1:0] ip, d;
    logic [IW-1:0]        res;
    ip = p >>> FRAC_BITS;
    d  = ip - CW'(mn);
    priority if (d < 0) begin
      res = '0;
    end else if (d > CW'(GRID_DIM - 2)) begin
      res = IW'(GRID_DIM - 2);
    end else begin
      res = d[IW-1:0];
    end
    return res;
  endfunction

  function automatic logic [AW-1:0] grid_addr(input logic [IW-1:0] x, input logic [IW-1:0] z);
    return AW'(x) * AW'(GRID_DIM) + AW'(z);
  endfunction

  assign in_ready = (state == ST_IDLE);

  // Write range check against the configured window.
  assign wdx = DXW'(cell_x_q) - DXW'(grid_min_x);
  assign wdz = DXW'(cell_z_q) - DXW'(grid_min_z);
  assign write_in_grid = (wdx >= 0) && (wdz >= 0) &&
                         (wdx < DXW'(GRID_DIM)) && (wdz < DXW'(GRID_DIM)) &&
                         (cell_x_q <= grid_max_x) && (cell_z_q <= grid_max_z);

  assign ox1 = IW'(ox_q + IW'(1));
  assign oz1 = IW'(oz_q + IW'(1));

  assign load_out = (state == ST_L2_ADD) && (!out_valid || out_ready);

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      grid_min_x <= RESET_MIN;
      grid_max_x <= RESET_MAX;
      grid_min_z <= RESET_MIN;
      grid_max_z <= RESET_MAX;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_MIN_X: grid_min_x <= $signed(cfg_data);
        REG_MAX_X: grid_max_x <= $signed(cfg_data);
        REG_MIN_Z: grid_min_z <= $signed(cfg_data);
        REG_MAX_Z: grid_max_z <= $signed(cfg_data);
      endcase
    end
  end

  // State register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Next state, grid port control and shared unit operand selection.
  always_comb begin
    state_next = state;
    ram_we     = 1'b0;
    ram_addr   = grid_addr(wdx[IW-1:0], wdz[IW-1:0]);
    op_a       = h0_q;
    op_b       = h1_q;
    op_f       = fx_q;
    case (state)
      ST_IDLE: begin
        if (in_valid) begin
          state_next = ST_CLAMP;
        end
      end
      ST_CLAMP: begin
        if (cmd_q == CMD_WRITE) begin
          ram_we     = write_in_grid;
          state_next = ST_IDLE;
        end else begin
          state_next = ST_OFFS;
        end
      end
      ST_OFFS:   state_next = ST_RD0;
      ST_RD0: begin
        ram_addr   = grid_addr(ox_q, oz_q);
        state_next = ST_RD1;
      end
      ST_RD1: begin
        ram_addr   = grid_addr(ox1, oz_q);
        state_next = ST_RD2;
      end
      ST_RD2: begin
        ram_addr   = grid_addr(ox1, oz1);
        state_next = ST_RD3;
      end
      ST_RD3: begin
        ram_addr   = grid_addr(ox_q, oz1);
        state_next = ST_L0_MUL;
      end
      ST_L0_MUL: state_next = ST_L0_ADD;
      ST_L0_ADD: state_next = ST_L1_MUL;
      ST_L1_MUL: begin
        op_a       = h3_q;
        op_b       = h2_q;
        state_next = ST_L1_ADD;
      end
      ST_L1_ADD: begin
        op_a       = h3_q;
        op_b       = h2_q;
        state_next = ST_L2_MUL;
      end
      ST_L2_MUL: begin
        op_a       = lerp_a_q;
        op_b       = lerp_b_q;
        op_f       = fz_q;
        state_next = ST_L2_ADD;
      end
      ST_L2_ADD: begin
        op_a = lerp_a_q;
        op_b = lerp_b_q;
        op_f = fz_q;
        if (load_out) begin
          state_next = ST_IDLE;
        end
      end
      default:   state_next = ST_IDLE;
    endcase
  end

  // Shared lerp unit: multiply the difference by the fraction, then floor and add.
  assign mul_res = (PW'(op_b) - PW'(op_a)) * $signed(PW'({1'b0, op_f}));
  assign add_sum = (prod_q >>> FRAC_BITS) + PW'(op_a);
  assign add_res = add_sum[HEIGHT_W-1:0];

  // Input capture.
  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      cmd_q     <= command;
      cell_x_q  <= cell_x;
      cell_z_q  <= cell_z;
      wheight_q <= write_height;
      qx_q      <= query_x;
      qz_q      <= query_z;
    end
  end

  // Query datapath registers, loaded step by step under the sequencer.
  always_ff @(posedge clk) begin
    case (state)
      ST_CLAMP: begin
        px_q <= clamp_axis(qx_q, grid_min_x, grid_max_x);
        pz_q <= clamp_axis(qz_q, grid_min_z, grid_max_z);
      end
      ST_OFFS: begin
        ox_q <= cell_offset(px_q, grid_min_x);
        oz_q <= cell_offset(pz_q, grid_min_z);
        fx_q <= px_q[FRAC_BITS-1:0];
        fz_q <= pz_q[FRAC_BITS-1:0];
      end
      ST_RD1:    h0_q <= $signed(ram_rdata);
      ST_RD2:    h1_q <= $signed(ram_rdata);
      ST_RD3:    h2_q <= $signed(ram_rdata);
      ST_L0_MUL: begin
        h3_q   <= $signed(ram_rdata);
        prod_q <= mul_res;
      end
      ST_L0_ADD: lerp_a_q <= add_res;
      ST_L1_MUL: prod_q   <= mul_res;
      ST_L1_ADD: lerp_b_q <= add_res;
      ST_L2_MUL: prod_q   <= mul_res;
      default: begin
      end
    endcase
  end

  // Output register; a held result blocks only the final load.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load_out) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      sampled_height <= add_res;
    end
  end

  hbs_ram #(
    .WIDTH(HEIGHT_W),
    .DEPTH(DEPTH)
  ) u_grid (
    .clk  (clk),
    .we   (ram_we),
    .addr (ram_addr),
    .wdata(wheight_q),
    .rdata(ram_rdata)
  );

  // The grid is only written while a write command is being applied.
  a_write_only_on_command: assert property (@(posedge clk) disable iff (rst)
    ram_we |-> (state == ST_CLAMP && cmd_q == CMD_WRITE))
    else $error("grid write outside a write command");

  // Query reads stay inside the grid.
  a_read_addr_in_range: assert property (@(posedge clk) disable iff (rst)
    (state == ST_RD0 || state == ST_RD1 || state == ST_RD2 || state == ST_RD3)
      |-> (ram_addr < AW'(DEPTH - 1) || ram_addr == AW'(DEPTH - 1)))
    else $error("grid read address beyond depth");

  // Cell offsets are saturated so the upper neighbor exists.
  a_offsets_saturated: assert property (@(posedge clk) disable iff (rst)
    (state == ST_RD0) |-> (ox_q <= IW'(GRID_DIM - 2) && oz_q <= IW'(GRID_DIM - 2)))
    else $error("cell offset not saturated");

  // Loading a result presents it and frees the input side.
  a_load_presents_result: assert property (@(posedge clk) disable iff (rst)
    load_out |=> (out_valid && state == ST_IDLE && sampled_height == $past(add_res)))
    else $error("result load did not present the result");

endmodule
